// ----- design/ipd_pkg.sv -----
package ipd_pkg;

  localparam int LEN_BITS      = 16;
  localparam int MAX_LEN_CHARS = 15;
  localparam int CNT_W         = $clog2(MAX_LEN_CHARS + 1);
  localparam int PROD_W        = LEN_BITS + 4;
  localparam int HIST_DEPTH    = 4;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    MODE_HUNT = 3'b001,
    MODE_LEN  = 3'b010,
    MODE_DATA = 3'b100
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_payload;
    logic       payload_last;
    logic       length_saturated;
  } res_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } hist_ctl_t;

  typedef struct packed {
    mode_t mode;
    logic  rem_zero;
  } fsm_stat_t;

endpackage

// ----- design/ipd_if.sv -----
interface ipd_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ipd_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_payload;
  logic       payload_last;
  logic       length_saturated;

  modport source (output valid, output out_byte, output is_payload, output payload_last,
                  output length_saturated, input ready);
  modport sink (input valid, input out_byte, input is_payload, input payload_last,
                input length_saturated, output ready);
endinterface

// ----- design/ipd_hist.sv -----
module ipd_hist (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [7:0]         b,
  input  ipd_pkg::hist_ctl_t hctl,
  output logic               match
);
  import ipd_pkg::*;

  logic [7:0] hist_r   [HIST_DEPTH];
  logic [7:0] hist_nxt [HIST_DEPTH];

  // Newest byte sits at index zero.
  assign match = (b == CH_COMMA) && (hist_r[0] == CH_D) && (hist_r[1] == CH_P) &&
                 (hist_r[2] == CH_I) && (hist_r[3] == CH_PLUS);

  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    if (adv && hctl.clear) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_nxt[i] = '0;
      end
    end else if (adv && hctl.shift) begin
      hist_nxt[0] = b;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_nxt[i] = hist_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (!rst_n) begin
        hist_r[i] <= '0;
      end else begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

endmodule

// ----- design/ipd_fsm.sv -----
module ipd_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [7:0]         b,
  input  logic               match,
  output ipd_pkg::res_t      res,
  output logic               emit,
  output ipd_pkg::hist_ctl_t hctl,
  output ipd_pkg::fsm_stat_t stat
);
  import ipd_pkg::*;

  mode_t               mode_r, mode_nxt;
  logic [LEN_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ended_r, ended_nxt;
  logic                sat_r, sat_nxt;
  logic [LEN_BITS-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0]   prod;
  logic                is_digit;

  // Digits are 0x30 to 0x39, so the low nibble is the digit value.
  assign prod = (PROD_W'(acc_r) << 3) + (PROD_W'(acc_r) << 1) + PROD_W'(b[3:0]);
  assign is_digit = b inside {[CH_ZERO:CH_NINE]};

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    ended_nxt = ended_r;
    sat_nxt   = sat_r;
    rem_nxt   = rem_r;
    res       = '0;
    res.out_byte = b;
    emit      = 1'b1;
    hctl      = '0;
    case (mode_r)
      MODE_DATA: begin
        res.is_payload       = 1'b1;
        res.payload_last     = (rem_r <= LEN_BITS'(1));
        res.length_saturated = sat_r;
        if (rem_r != '0) begin
          rem_nxt = rem_r - LEN_BITS'(1);
        end
        if (rem_r <= LEN_BITS'(1)) begin
          mode_nxt   = MODE_HUNT;
          hctl.clear = 1'b1;
        end
      end
      MODE_LEN: begin
        if (b == CH_COLON) begin
          emit      = 1'b0;
          cnt_nxt   = '0;
          ended_nxt = 1'b0;
          if (acc_r == '0) begin
            mode_nxt   = MODE_HUNT;
            hctl.clear = 1'b1;
          end else begin
            rem_nxt  = acc_r;
            mode_nxt = MODE_DATA;
          end
        end else if (cnt_r < CNT_W'(MAX_LEN_CHARS)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (!ended_r && is_digit) begin
            if (prod > PROD_W'(LEN_MAX)) begin
              acc_nxt = LEN_MAX;
              sat_nxt = 1'b1;
            end else begin
              acc_nxt = prod[LEN_BITS-1:0];
            end
          end else begin
            ended_nxt = 1'b1;
          end
        end
      end
      default: begin
        if (match) begin
          hctl.clear = 1'b1;
          mode_nxt   = MODE_LEN;
          acc_nxt    = '0;
          cnt_nxt    = '0;
          ended_nxt  = 1'b0;
          sat_nxt    = 1'b0;
        end else begin
          hctl.shift = 1'b1;
        end
      end
    endcase
  end

  assign stat.mode     = mode_r;
  assign stat.rem_zero = (rem_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HUNT;
      acc_r   <= '0;
      cnt_r   <= '0;
      ended_r <= 1'b0;
      sat_r   <= 1'b0;
      rem_r   <= '0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      ended_r <= ended_nxt;
      sat_r   <= sat_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// ----- design/ipd_frame_length_parser_core.sv -----
// Channel  Direction  Payload
// in_ch    sink       rx_byte[7:0]
// out_ch   source     out_byte[7:0], is_payload, payload_last, length_saturated
//
// Each request passes an input register and then a result register, and one request
// is taken per cycle while the result register is not stalled.
// The colon that closes a length field produces no result.
// Reset is synchronous and active low; it returns the parser to marker hunting.
// A stalled result register holds the input register, which then stops taking requests.
module ipd_frame_length_parser_core (
  input logic      clk,
  input logic      rst_n,
  ipd_in_if.sink   in_ch,
  ipd_out_if.source out_ch
);
  import ipd_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r, out_vld_nxt;
  res_t       out_res_r;
  logic       adv;
  logic       emit;
  logic       match;
  res_t       res;
  hist_ctl_t  hctl;
  fsm_stat_t  stat;

  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  ipd_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .b     (in_byte_r),
    .hctl  (hctl),
    .match (match)
  );

  ipd_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .b     (in_byte_r),
    .match (match),
    .res   (res),
    .emit  (emit),
    .hctl  (hctl),
    .stat  (stat)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = emit;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (adv && emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.out_byte         = out_res_r.out_byte;
  assign out_ch.is_payload       = out_res_r.is_payload;
  assign out_ch.payload_last     = out_res_r.payload_last;
  assign out_ch.length_saturated = out_res_r.length_saturated;

  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.payload_last |-> out_res_r.is_payload)
    else $error("payload_last set on a non-payload byte");

  a_data_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mode == MODE_DATA |-> !stat.rem_zero)
    else $error("payload mode entered with zero bytes remaining");

  a_drop_only_colon: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !emit |-> stat.mode == MODE_LEN && in_byte_r == CH_COLON)
    else $error("byte dropped outside the length terminator");

  a_marker_enters_len: assert property (@(posedge clk) disable iff (!rst_n)
    adv && match && stat.mode == MODE_HUNT |=> stat.mode == MODE_LEN)
    else $error("marker did not start length parsing");

endmodule

// ----- sim/ipd_frame_length_parser_core_test.sv -----
`timescale 1ns / 100ps

module ipd_frame_length_parser_core_test;
  import ipd_pkg::*;

  typedef enum int unsigned {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN,
    RX_CHOKED
  } rx_mode_e;

  typedef enum int unsigned {
    LEN_PLAIN,
    LEN_ZEROS,
    LEN_JUNK,
    LEN_ZERO,
    LEN_OVERLONG,
    LEN_WIDE
  } len_kind_e;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ipd_in_if  in_ch (clk);
  ipd_out_if out_ch (clk);

  ipd_frame_length_parser_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [7:0]          hist [HIST_DEPTH] = '{default: 8'h00};
  mode_t               p_mode      = MODE_HUNT;
  logic [LEN_BITS-1:0] len_acc     = '0;
  logic [CNT_W-1:0]    len_chars   = '0;
  logic                digits_done = 1'b0;
  logic                len_sat     = 1'b0;
  logic [LEN_BITS-1:0] pay_left    = '0;

  res_t        pending_fwd [$];
  dir_row_t    dir_rows [$];
  string       marker_txt = "+IPD,";
  bit          drv_typed  = 1'b0;
  res_t        drv_want   = '0;
  int unsigned burst_left = 0;
  int unsigned n_sent     = 0;
  int unsigned n_results  = 0;
  int unsigned n_payload  = 0;
  int unsigned n_frames   = 0;
  int unsigned n_sat      = 0;
  int unsigned n_fail     = 0;

  rx_mode_e    rx_mode    = RX_OPEN;
  int unsigned rx_left    = 0;
  logic [7:0]  rx_pat     = 8'hFF;
  logic [2:0]  rx_phase   = '0;

  function automatic void back_to_hunt();
    p_mode = MODE_HUNT;
    hist   = '{default: 8'h00};
  endfunction

  function automatic bit frame_parse(input logic [7:0] b, output res_t fwd);
    logic [PROD_W-1:0] prod;
    bit                emits;
    fwd          = '0;
    fwd.out_byte = b;
    emits        = 1'b1;
    case (p_mode)
      MODE_DATA: begin
        fwd.is_payload       = 1'b1;
        fwd.payload_last     = (pay_left <= 1);
        fwd.length_saturated = len_sat;
        if (pay_left != 0) pay_left = pay_left - 1'b1;
        if (pay_left == 0) back_to_hunt();
      end
      MODE_LEN: begin
        if (b == CH_COLON) begin
          // The closing colon is swallowed and forwards nothing.
          len_chars   = '0;
          digits_done = 1'b0;
          emits       = 1'b0;
          if (len_acc == 0) begin
            back_to_hunt();
          end else begin
            pay_left = len_acc;
            p_mode   = MODE_DATA;
          end
        end else if (len_chars < MAX_LEN_CHARS) begin
          len_chars = len_chars + 1'b1;
          if (!digits_done && b >= CH_ZERO && b <= CH_NINE) begin
            prod = PROD_W'(len_acc) * PROD_W'(10) + PROD_W'(b - CH_ZERO);
            if (prod > PROD_W'(LEN_MAX)) begin
              len_acc = LEN_MAX;
              len_sat = 1'b1;
            end else begin
              len_acc = prod[LEN_BITS-1:0];
            end
          end else begin
            digits_done = 1'b1;
          end
        end
      end
      default: begin
        p_mode = MODE_HUNT;
        if (b == CH_COMMA && hist[0] == CH_D && hist[1] == CH_P && hist[2] == CH_I &&
            hist[3] == CH_PLUS) begin
          hist        = '{default: 8'h00};
          p_mode      = MODE_LEN;
          len_acc     = '0;
          len_chars   = '0;
          digits_done = 1'b0;
          len_sat     = 1'b0;
        end else begin
          for (int i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
          hist[0] = b;
        end
      end
    endcase
    return emits;
  endfunction

  task automatic note_failure(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    res_t pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_byte, out_ch.is_payload, out_ch.payload_last,
               out_ch.length_saturated};
        n_results++;
        if (got.is_payload) n_payload++;
        if (got.payload_last) n_frames++;
        if (got.length_saturated) n_sat++;
        if (pending_fwd.size() == 0) begin
          note_failure($sformatf("unexpected result: byte %02h pay %b last %b sat %b",
                                 got.out_byte, got.is_payload, got.payload_last,
                                 got.length_saturated));
        end else begin
          want = pending_fwd.pop_front();
          if (got.out_byte !== want.out_byte || got.is_payload !== want.is_payload ||
              got.payload_last !== want.payload_last ||
              got.length_saturated !== want.length_saturated) begin
            note_failure($sformatf(
              "mismatch: expected byte %02h pay %b last %b sat %b, got byte %02h pay %b last %b sat %b",
              want.out_byte, want.is_payload, want.payload_last, want.length_saturated,
              got.out_byte, got.is_payload, got.payload_last, got.length_saturated));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (frame_parse(in_ch.rx_byte, pred)) pending_fwd.push_back(drv_typed ? drv_want : pred);
      end
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 128);
      rx_pat  = 8'($urandom) | 8'h01;
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:    out_ch.ready <= 1'b1;
      RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 9) < 7);
      RX_PATTERN: out_ch.ready <= rx_pat[rx_phase];
      default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_req(input logic [7:0] b, input bit typed, input res_t want);
    int unsigned gap;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    drv_typed = typed;
    drv_want  = want;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 90);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(0, 15);
        gap        = $urandom_range(0, 6);
      end
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_req(b, 1'b0, '0);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_payload(input int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) send_byte(CH_COLON);
      else if (pick == 1) send_byte(marker_txt[$urandom_range(0, 4)]);
      else send_byte(8'($urandom));
    end
  endtask

  task automatic send_frame(input string lead);
    len_kind_e   kind;
    int unsigned v;
    logic [7:0]  b;
    kind = len_kind_e'($urandom_range(0, 5));
    send_text({lead, marker_txt});
    case (kind)
      LEN_PLAIN: begin
        v = $urandom_range(1, 40);
        send_text($sformatf("%0d", v));
      end
      LEN_ZEROS: begin
        v = $urandom_range(1, 25);
        repeat ($urandom_range(1, 6)) send_byte(CH_ZERO);
        send_text($sformatf("%0d", v));
      end
      LEN_JUNK: begin
        v = $urandom_range(1, 30);
        send_text($sformatf("%0d", v));
        do b = 8'($urandom); while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
        send_byte(b);
        if ($urandom_range(0, 1)) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      LEN_ZERO: begin
        v = 0;
        case ($urandom_range(0, 2))
          0: ;
          1: send_byte(CH_ZERO);
          default: send_text("00x7");
        endcase
      end
      LEN_OVERLONG: begin
        v = $urandom_range(1, 9);
        repeat (MAX_LEN_CHARS - 1) send_byte(CH_ZERO);
        send_byte(8'(CH_ZERO + v));
        repeat ($urandom_range(1, 3)) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      default: begin
        v = $urandom_range(41, 300);
        send_text($sformatf("%0d", v));
      end
    endcase
    send_byte(CH_COLON);
    send_payload(v);
    if (kind == LEN_ZERO && $urandom_range(0, 1)) send_text("IPD,");
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_fwd.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic dir_row_t dir_row(input logic [7:0] b, input bit typed = 1'b0,
                                       input res_t want = '0);
    dir_row_t r;
    r.rx    = b;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  initial begin
    int unsigned pick;
    int unsigned k;
    logic [7:0]  b;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      dir_row(8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0}),
      dir_row(8'hFF, 1'b1, {8'hFF, 1'b0, 1'b0, 1'b0}),
      dir_row(CH_PLUS), dir_row(CH_I), dir_row(CH_P), dir_row(CH_D), dir_row(CH_COMMA),
      dir_row(8'h32), dir_row(8'h78), dir_row(8'h37), dir_row(CH_COLON),
      dir_row(8'hFF, 1'b1, {8'hFF, 1'b1, 1'b0, 1'b0}),
      dir_row(8'h00, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0}),
      dir_row(CH_PLUS), dir_row(CH_I), dir_row(CH_P), dir_row(CH_D), dir_row(CH_COMMA),
      dir_row(CH_ZERO), dir_row(CH_COLON),
      dir_row(CH_COLON, 1'b1, {CH_COLON, 1'b0, 1'b0, 1'b0}),
      dir_row(8'h80, 1'b1, {8'h80, 1'b0, 1'b0, 1'b0}),
      dir_row(8'h7F, 1'b1, {8'h7F, 1'b0, 1'b0, 1'b0})
    };
    foreach (dir_rows[i]) send_req(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    while (n_sent < 500) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame("");
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end else if (pick < 90) begin
        k = $urandom_range(1, 4);
        send_text(marker_txt.substr(0, k - 1));
        do b = 8'($urandom); while (b == marker_txt[k]);
        send_byte(b);
      end else if (pick < 95) begin
        send_frame("+I");
      end else begin
        send_text("+IPD,+IPD,7:");
      end
    end

    // The sender holds off until the block is empty, then opens one clamped frame.
    // Only the start of its payload is sent, so the run ends inside that frame.
    drain_results();
    send_text("+IPD,65536:");
    send_payload(40);

    drain_results();
    repeat (10) @(posedge clk);
    if (pending_fwd.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_fwd.size()));
    $display("Run covered %0d requests and %0d forwarded bytes, %0d of them payload.",
             n_sent, n_results, n_payload);
    $display("Frames closed: %0d, clamped payload bytes: %0d, failures: %0d.",
             n_frames, n_sat, n_fail);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", pending_fwd.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- ipd_frame_length_parser_core.f -----
design/ipd_pkg.sv
design/ipd_if.sv
design/ipd_hist.sv
design/ipd_fsm.sv
design/ipd_frame_length_parser_core.sv
sim/ipd_frame_length_parser_core_test.sv
